>>> hdl/rflm_pkg.sv
// ----------------------------------------------------------------------------
// rflm_pkg: shared types and constants of the register frame link master
// Item and result layouts, opcodes, status codes and frame byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rflm_pkg;

    localparam int MAX_READ_BYTES_DEF  = 32;
    localparam int MAX_WRITE_BYTES_DEF = 4;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RXBYTE  = 2'd2,
        OP_TIMEOUT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_RESP  = 3'd1,
        ST_ODD_ADDR = 3'd2,
        ST_NACK     = 3'd3,
        ST_CKSUM    = 3'd4,
        ST_UNKNOWN  = 3'd5,
        ST_BUSY     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAME,
        S_JUDGE,
        S_RDREQ,
        S_DATA,
        S_STATUS
    } t_state;

    localparam logic [7:0] SOF_BYTE    = 8'hA5;
    localparam logic [7:0] READ_LEN    = 8'h08;
    localparam logic [7:0] SET_PTR     = 8'h41;
    localparam logic [7:0] PTR_HIGH    = 8'h00;
    localparam logic [7:0] CMD_READ    = 8'h4E;
    localparam logic [7:0] CMD_WRITE   = 8'h4D;
    localparam logic [7:0] ACK_BYTE    = 8'h06;
    localparam logic [7:0] NACK_BYTE   = 8'h15;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  reg_addr;
        logic [5:0]  byte_count;
        logic [31:0] write_value;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic [15:0] nack_total;
        logic [15:0] checksum_error_total;
        logic [15:0] no_response_total;
        logic        last;
    } t_result;

    // Header and value bytes of a frame; the trailing sum is added by the caller.
    function automatic logic [7:0] frame_byte(
        input logic [3:0]  idx,
        input logic        is_write,
        input logic [7:0]  addr,
        input logic [5:0]  cnt,
        input logic [31:0] value
    );
        logic [7:0] b;
        begin
            case (idx)
                4'd0:    b = SOF_BYTE;
                4'd1:    b = is_write ? ({2'b00, cnt} + 8'd8) : READ_LEN;
                4'd2:    b = SET_PTR;
                4'd3:    b = PTR_HIGH;
                4'd4:    b = addr;
                4'd5:    b = is_write ? CMD_WRITE : CMD_READ;
                4'd6:    b = {2'b00, cnt};
                4'd7:    b = value[7:0];
                4'd8:    b = value[15:8];
                4'd9:    b = value[23:16];
                4'd10:   b = value[31:24];
                default: b = 8'h00;
            endcase
            frame_byte = b;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/rflm_if.sv
// ----------------------------------------------------------------------------
// rflm_if: valid/ready channels of the register frame link master
// One interface for request words and one for result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rflm_in_if;
    logic               valid;
    logic               ready;
    rflm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rflm_out_if;
    logic              valid;
    logic              ready;
    rflm_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/rflm_ram.sv
// ----------------------------------------------------------------------------
// rflm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rflm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 36
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hdl/rflm_out_stage.sv
// ----------------------------------------------------------------------------
// rflm_out_stage: result output register
// Holds one result word so that the controller runs ahead of the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module rflm_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rflm_pkg::t_result i_data,
    output logic                   o_ready,
    rflm_out_if.source             o_out
);

    logic              r_valid;
    logic              n_valid;
    rflm_pkg::t_result r_data;

    assign o_ready = !r_valid || o_out.ready;
    assign n_valid = i_valid || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

endmodule

`default_nettype wire

>>> hdl/register_frame_link_master.sv
// ----------------------------------------------------------------------------
// register_frame_link_master: host side of a byte-framed register link
// Builds request frames, collects the response into a buffer RAM, judges it
// and replays verified read data, keeping error counters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Words carried
//  i_in      sink       op, reg_addr, byte_count, write_value, rx_byte
//  o_out     source     out_kind, out_byte, status, three totals, last
//
//  A request word is taken in the idle state; its frame then leaves at one
//  word a cycle while the output accepts (8 words for a read, 8 + count for
//  a write), or one status word. Received bytes and timeouts are taken in
//  idle; a word ending collection passes the judging state, a read-request
//  and a data state per data word (registered RAM read), the status state.
//  Reset is synchronous and needs no clearing pass; the buffer is only read
//  where it was written. A stalled output holds the controller in place.
// ----------------------------------------------------------------------------
`default_nettype none

module register_frame_link_master #(
    parameter int MAX_READ_BYTES  = rflm_pkg::MAX_READ_BYTES_DEF,
    parameter int MAX_WRITE_BYTES = rflm_pkg::MAX_WRITE_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rflm_in_if.sink    i_in,
    rflm_out_if.source o_out
);

    localparam int RBUF_LEN = MAX_READ_BYTES + 4;
    localparam int ADDR_W   = $clog2(RBUF_LEN);
    localparam int RCNT_W   = $clog2(RBUF_LEN + 1);
    localparam logic [5:0]        MAX_RD = 6'(MAX_READ_BYTES);
    localparam logic [5:0]        MAX_WR = 6'(MAX_WRITE_BYTES);
    localparam logic [RCNT_W-1:0] ONE    = RCNT_W'(1);
    localparam logic [RCNT_W-1:0] TWO    = RCNT_W'(2);
    localparam logic [RCNT_W-1:0] THREE  = RCNT_W'(3);

    rflm_pkg::t_state  r_state,   n_state;
    rflm_pkg::t_phase  r_phase,   n_phase;
    rflm_pkg::t_status r_status,  n_status;
    logic [5:0]        r_pending, n_pending;
    logic [RCNT_W-1:0] r_rcvd,    n_rcvd;
    logic [7:0]        r_first,   n_first;
    logic [7:0]        r_last,    n_last;
    logic [7:0]        r_sum,     n_sum;
    logic [15:0]       r_nack,    n_nack;
    logic [15:0]       r_chk,     n_chk;
    logic [15:0]       r_nores,   n_nores;
    logic              r_is_wr,   n_is_wr;
    logic [7:0]        r_addr,    n_addr;
    logic [5:0]        r_cnt,     n_cnt;
    logic [31:0]       r_value,   n_value;
    logic [3:0]        r_fidx,    n_fidx;
    logic [3:0]        r_flast,   n_flast;
    logic [7:0]        r_fsum,    n_fsum;
    logic [RCNT_W-1:0] r_rd_idx,  n_rd_idx;
    logic [RCNT_W-1:0] r_rd_end,  n_rd_end;

    logic              w_slot;
    logic              w_emit;
    rflm_pkg::t_result w_res;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [7:0]        w_rd_data;

    rflm_ram #(
        .WIDTH (8),
        .DEPTH (RBUF_LEN)
    ) u_rbuf (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_rcvd[ADDR_W-1:0]),
        .i_wr_data (i_in.data.rx_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    rflm_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_emit),
        .i_data  (w_res),
        .o_ready (w_slot),
        .o_out   (o_out)
    );

    assign i_in.ready = (r_state == rflm_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rflm_pkg::S_IDLE;
            r_phase   <= rflm_pkg::PH_IDLE;
            r_pending <= '0;
            r_rcvd    <= '0;
            r_nack    <= '0;
            r_chk     <= '0;
            r_nores   <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_rcvd    <= n_rcvd;
            r_nack    <= n_nack;
            r_chk     <= n_chk;
            r_nores   <= n_nores;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_first  <= n_first;
        r_last   <= n_last;
        r_sum    <= n_sum;
        r_is_wr  <= n_is_wr;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_value  <= n_value;
        r_fidx   <= n_fidx;
        r_flast  <= n_flast;
        r_fsum   <= n_fsum;
        r_rd_idx <= n_rd_idx;
        r_rd_end <= n_rd_end;
    end

    always_comb begin
        logic              acc;
        logic [5:0]        cnt_rd;
        logic [5:0]        cnt_wr;
        logic [RCNT_W-1:0] limit;
        logic [RCNT_W-1:0] rcvd_inc;
        logic [RCNT_W-1:0] data_end;
        logic [7:0]        fbyte;

        n_state   = r_state;
        n_phase   = r_phase;
        n_status  = r_status;
        n_pending = r_pending;
        n_rcvd    = r_rcvd;
        n_first   = r_first;
        n_last    = r_last;
        n_sum     = r_sum;
        n_nack    = r_nack;
        n_chk     = r_chk;
        n_nores   = r_nores;
        n_is_wr   = r_is_wr;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_value   = r_value;
        n_fidx    = r_fidx;
        n_flast   = r_flast;
        n_fsum    = r_fsum;
        n_rd_idx  = r_rd_idx;
        n_rd_end  = r_rd_end;
        w_emit    = 1'b0;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;

        acc      = i_in.valid && (r_state == rflm_pkg::S_IDLE);
        cnt_rd   = (i_in.data.byte_count > MAX_RD) ? MAX_RD : i_in.data.byte_count;
        cnt_wr   = (i_in.data.byte_count == 6'd0) ? 6'd1 :
                   ((i_in.data.byte_count > MAX_WR) ? MAX_WR : i_in.data.byte_count);
        limit    = (r_phase == rflm_pkg::PH_READ) ?
                   (RCNT_W'(r_pending) + RCNT_W'(4)) : TWO;
        rcvd_inc = r_rcvd + ONE;
        data_end = ((r_rcvd - ONE) < (RCNT_W'(r_pending) + TWO)) ?
                   (r_rcvd - ONE) : (RCNT_W'(r_pending) + TWO);
        fbyte    = (r_fidx == r_flast) ? r_fsum :
                   rflm_pkg::frame_byte(r_fidx, r_is_wr, r_addr, r_cnt, r_value);

        w_res.out_kind             = rflm_pkg::KIND_STATUS;
        w_res.out_byte             = 8'h00;
        w_res.status               = r_status;
        w_res.nack_total           = r_nack;
        w_res.checksum_error_total = r_chk;
        w_res.no_response_total    = r_nores;
        w_res.last                 = 1'b1;

        case (r_state)
            rflm_pkg::S_IDLE: begin
                if (acc) begin
                    case (rflm_pkg::t_op'(i_in.data.op))
                        rflm_pkg::OP_READ, rflm_pkg::OP_WRITE: begin
                            if (r_phase != rflm_pkg::PH_IDLE) begin
                                n_status = rflm_pkg::ST_BUSY;
                                n_state  = rflm_pkg::S_STATUS;
                            end else if (i_in.data.reg_addr[0]) begin
                                n_nack   = r_nack + 16'd1;
                                n_status = rflm_pkg::ST_ODD_ADDR;
                                n_state  = rflm_pkg::S_STATUS;
                            end else begin
                                n_is_wr   = (rflm_pkg::t_op'(i_in.data.op) ==
                                             rflm_pkg::OP_WRITE);
                                n_cnt     = n_is_wr ? cnt_wr : cnt_rd;
                                n_addr    = i_in.data.reg_addr;
                                n_value   = i_in.data.write_value;
                                n_fidx    = 4'd0;
                                n_flast   = n_is_wr ? (4'd7 + n_cnt[3:0]) : 4'd7;
                                n_fsum    = 8'h00;
                                n_phase   = n_is_wr ? rflm_pkg::PH_WRITE :
                                                      rflm_pkg::PH_READ;
                                n_pending = n_cnt;
                                n_rcvd    = '0;
                                n_sum     = 8'h00;
                                n_state   = rflm_pkg::S_FRAME;
                            end
                        end
                        rflm_pkg::OP_RXBYTE: begin
                            if (r_phase != rflm_pkg::PH_IDLE) begin
                                w_wr_en = 1'b1;
                                n_rcvd  = rcvd_inc;
                                n_sum   = r_sum + i_in.data.rx_byte;
                                n_last  = i_in.data.rx_byte;
                                if (r_rcvd == '0) begin
                                    n_first = i_in.data.rx_byte;
                                end
                                if (rcvd_inc >= limit) begin
                                    n_state = rflm_pkg::S_JUDGE;
                                end
                            end
                        end
                        default: begin
                            if (r_phase != rflm_pkg::PH_IDLE) begin
                                n_state = rflm_pkg::S_JUDGE;
                            end
                        end
                    endcase
                end
            end
            rflm_pkg::S_FRAME: begin
                w_res.out_kind = rflm_pkg::KIND_TX;
                w_res.out_byte = fbyte;
                w_res.status   = rflm_pkg::ST_OK;
                w_res.last     = (r_fidx == r_flast);
                if (w_slot) begin
                    w_emit = 1'b1;
                    n_fsum = r_fsum + fbyte;
                    n_fidx = r_fidx + 4'd1;
                    if (r_fidx == r_flast) begin
                        n_state = rflm_pkg::S_IDLE;
                    end
                end
            end
            rflm_pkg::S_JUDGE: begin
                // The running sum covers every byte, so the checked sum drops the last one.
                n_state = rflm_pkg::S_STATUS;
                if (r_rcvd == '0) begin
                    n_nores  = r_nores + 16'd1;
                    n_status = rflm_pkg::ST_NO_RESP;
                end else if (r_phase == rflm_pkg::PH_READ && r_rcvd >= THREE &&
                             r_first == rflm_pkg::ACK_BYTE) begin
                    if ((r_sum - r_last) == r_last) begin
                        n_status = rflm_pkg::ST_OK;
                        n_rd_idx = TWO;
                        n_rd_end = data_end;
                        if (data_end > TWO) begin
                            n_state = rflm_pkg::S_RDREQ;
                        end
                    end else begin
                        n_chk    = r_chk + 16'd1;
                        n_status = rflm_pkg::ST_CKSUM;
                    end
                end else if (r_phase == rflm_pkg::PH_WRITE &&
                             r_first == rflm_pkg::ACK_BYTE) begin
                    n_status = rflm_pkg::ST_OK;
                end else if (r_first == rflm_pkg::NACK_BYTE) begin
                    n_nack   = r_nack + 16'd1;
                    n_status = rflm_pkg::ST_NACK;
                end else begin
                    n_status = rflm_pkg::ST_UNKNOWN;
                end
                n_phase = rflm_pkg::PH_IDLE;
                n_rcvd  = '0;
            end
            rflm_pkg::S_RDREQ: begin
                w_rd_en = 1'b1;
                n_state = rflm_pkg::S_DATA;
            end
            rflm_pkg::S_DATA: begin
                w_res.out_kind = rflm_pkg::KIND_DATA;
                w_res.out_byte = w_rd_data;
                w_res.status   = rflm_pkg::ST_OK;
                w_res.last     = 1'b0;
                if (w_slot) begin
                    w_emit   = 1'b1;
                    n_rd_idx = r_rd_idx + ONE;
                    n_state  = ((r_rd_idx + ONE) == r_rd_end) ? rflm_pkg::S_STATUS :
                                                                 rflm_pkg::S_RDREQ;
                end
            end
            rflm_pkg::S_STATUS: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    n_state = rflm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rflm_pkg::S_IDLE;
            end
        endcase
    end

    a_judge_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rflm_pkg::S_JUDGE) |=> (r_phase == rflm_pkg::PH_IDLE && r_rcvd == '0))
        else $error("collection state not cleared after judging");

    a_rcvd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rflm_pkg::PH_READ) |-> (r_rcvd <= RCNT_W'(r_pending) + RCNT_W'(4)))
        else $error("response count beyond collection limit");

    a_data_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_state == rflm_pkg::S_DATA) |-> (r_status == rflm_pkg::ST_OK))
        else $error("read data word emitted for an unverified response");

    a_chk_by_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chk != $past(r_chk)) |-> ($past(r_state) == rflm_pkg::S_JUDGE))
        else $error("checksum error total changed outside judging");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rflm_pkg::PH_IDLE) |-> (r_rcvd == '0))
        else $error("bytes counted while no transaction is open");

endmodule

`default_nettype wire
